@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define APU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("apu check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define APU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("apu check failed");

// The consequent must hold whenever the antecedent does, reset included.
`define APU_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("apu check failed");

`endif

@@ hw/rtl/apu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AdaGrad update package
// Types, field widths and register codes shared by the update engine files.
// ----------------------------------------------------------------------------
package apu_pkg;

   localparam int WORD_W  = 10;
   localparam int ELEM_W  = 6;
   localparam int VAL_W   = 32;
   localparam int HIST_W  = 40;
   localparam int LR_W    = 24;
   localparam int SKIP_W  = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int WORDS_DEFAULT     = 1024;
   localparam int DIM_DEFAULT       = 64;
   localparam int FRAC_BITS_DEFAULT = 24;

   localparam logic [LR_W-1:0]   LR_RESET   = LR_W'(167772);
   localparam logic [SKIP_W-1:0] SKIP_RESET = '1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_WORD     = 2'd1;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_APPLY = 2'd2
   } action_type;

   typedef struct packed {
      action_type              action;
      logic [WORD_W-1:0]       word;
      logic [ELEM_W-1:0]       element;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]       out_word;
      logic [ELEM_W-1:0]       out_element;
      logic signed [VAL_W-1:0] new_weight;
   } rsp_type;

endpackage

@@ hw/rtl/apu_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read; a read of the address being written returns the old data, registered.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/apu_root.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial square root
// Takes the radicand two bits per cycle and settles one root bit per cycle.
// ----------------------------------------------------------------------------
module apu_root #(
   parameter int RAD_W = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [RAD_W-1:0]       radicand,
   output logic                   done,
   output logic [RAD_W/2-1:0]     root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+1:0] rem_in;
   logic [ROOT_W+1:0] trial;

   // One restoring step: bring down a bit pair, try 4*root+1.
   always_comb begin
      rem_in = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff <= rad_ff << 2;
            if (rem_in >= trial) begin
               rem_ff  <= rem_in - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_in;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/apu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division that settles one quotient bit per cycle. A quotient
// that does not fit in Q_W bits returns all ones; a zero divisor returns 0.
// ----------------------------------------------------------------------------
module apu_div #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 32,
   parameter int Q_W   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [Q_W-1:0]   quot
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   lo_ff;
   logic [Q_W-1:0]   quot_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             overflow;

   // The quotient overflows when the upper part is already not below den.
   always_comb begin
      trial    = {rem_ff, lo_ff[Q_W-1]};
      overflow = (num >> Q_W) >= NUM_W'(den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            den_ff <= den;
            rem_ff <= DEN_W'(num >> Q_W);
            lo_ff  <= num[Q_W-1:0];
            if (den == '0) begin
               quot_ff <= '0;
               done_ff <= 1'b1;
            end else if (overflow) begin
               quot_ff <= '1;
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= CNT_W'(Q_W);
            end
         end else if (busy_ff) begin
            lo_ff <= lo_ff << 1;
            if (trial >= {1'b0, den_ff}) begin
               rem_ff  <= DEN_W'(trial - {1'b0, den_ff});
               quot_ff <= {quot_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_ff  <= DEN_W'(trial);
               quot_ff <= {quot_ff[Q_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ hw/rtl/adagrad_parameter_update_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AdaGrad parameter update engine
// Holds weight, gradient and square-sum history per table entry and applies
// saturating AdaGrad updates, one item at a time.
// ----------------------------------------------------------------------------
// One item is worked at a time; busy is high from the cycle after start is
// taken until the item is finished. A load or an add passes the address,
// wait and execute states, and an item with a bad address or an unused
// action ends after the address state. An apply to the skip word ends after
// execute; any other apply goes on through square, history, root, divide,
// multiply and write-back, with a root of ROOT_W = ceil((40 + FRAC_BITS) / 2)
// bits. The bit-serial square root and the bit-serial divider each settle
// one bit per cycle. An apply whose quotient saturates skips the divider's
// bit loop. The new weight is shown for exactly one cycle with rsp_valid, in
// the cycle busy falls; the receiver cannot stall it. The stores come up
// undefined and need no clearing pass; load an entry before adding to it or applying it.
module adagrad_parameter_update_top #(
   parameter int WORDS     = apu_pkg::WORDS_DEFAULT,
   parameter int DIM       = apu_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = apu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  apu_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   output apu_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [apu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [apu_pkg::CSR_DATA_W-1:0]       csr_data
);

   import apu_pkg::*;

   localparam int DEPTH  = WORDS * DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RAD_W  = HIST_W + FRAC_BITS + (FRAC_BITS % 2);
   localparam int ROOT_W = RAD_W / 2;
   localparam int NUM_W  = VAL_W + FRAC_BITS;
   localparam logic [HIST_W-1:0] HIST_ONE = HIST_W'(1) << FRAC_BITS;
   localparam logic [63:0]       HIST_MAX = 64'((65'd1 << HIST_W) - 65'd1);

   typedef enum logic [3:0] {
      S_IDLE, S_ADDR, S_WAIT, S_EXEC, S_SQ, S_HIST, S_ROOT, S_DIV, S_MUL, S_WB
   } state_type;

   state_type           state_ff;
   req_type             req_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [LR_W-1:0]     lr_ff;
   logic [SKIP_W-1:0]   skip_ff;
   logic                neg_ff;
   logic [VAL_W-1:0]    gmag_ff;
   logic [VAL_W-1:0]    w_ff;
   logic [HIST_W-1:0]   hist_ff;
   logic [63:0]         sq_ff;
   logic [VAL_W-1:0]    qmag_ff;
   logic [VAL_W+LR_W-1:0] step_ff;

   logic [VAL_W-1:0]    w_rd, g_rd;
   logic [HIST_W-1:0]   h_rd;
   logic                w_we, g_we, h_we;
   logic [VAL_W-1:0]    w_wdata, g_wdata;
   logic [HIST_W-1:0]   h_wdata;

   logic                in_range;
   logic                skip_hit;
   logic [VAL_W:0]      gsum;
   logic [VAL_W-1:0]    gsat;
   logic [63:0]         hsum;
   logic [HIST_W-1:0]   hnew;
   logic [RAD_W-1:0]    radicand;
   logic                root_go, root_done;
   logic [ROOT_W-1:0]   root_val;
   logic [NUM_W-1:0]    div_num;
   logic                div_go, div_done;
   logic [VAL_W-1:0]    quot;
   logic [VAL_W-1:0]    qlim;
   logic [VAL_W-1:0]    qclamp;
   logic [VAL_W-1:0]    smag;
   logic [VAL_W+1:0]    wdiff;
   logic [VAL_W-1:0]    wnew;

   // Address check and skip match for the held item.
   always_comb begin
      in_range = (int'(req_ff.word) < WORDS) && (int'(req_ff.element) < DIM);
      skip_hit = (skip_ff == {1'b0, req_ff.word});
   end

   // Saturating gradient accumulate.
   always_comb begin
      gsum = {g_rd[VAL_W-1], g_rd} + {req_ff.value[VAL_W-1], req_ff.value};
      if (gsum[VAL_W] != gsum[VAL_W-1]) begin
         gsat = gsum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         gsat = gsum[VAL_W-1:0];
      end
   end

   // History plus the squared gradient, clamped to the history width.
   always_comb begin
      hsum = 64'(hist_ff) + (sq_ff >> FRAC_BITS);
      hnew = (hsum > HIST_MAX) ? '1 : hsum[HIST_W-1:0];
      radicand = RAD_W'(hnew) << FRAC_BITS;
      div_num  = NUM_W'(gmag_ff) << FRAC_BITS;
      root_go  = (state_ff == S_HIST);
      div_go   = (state_ff == S_ROOT) && root_done;
   end

   // Quotient limit depends on the gradient's sign.
   always_comb begin
      qlim   = neg_ff ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      qclamp = (quot > qlim) ? qlim : quot;
   end

   // Weight minus the signed step, saturated.
   always_comb begin
      smag  = VAL_W'(step_ff >> LR_W);
      if (neg_ff) begin
         wdiff = {{2{w_ff[VAL_W-1]}}, w_ff} + {2'b00, smag};
      end else begin
         wdiff = {{2{w_ff[VAL_W-1]}}, w_ff} - {2'b00, smag};
      end
      if ((wdiff[VAL_W+1:VAL_W-1] != 3'b000) && (wdiff[VAL_W+1:VAL_W-1] != 3'b111)) begin
         wnew = wdiff[VAL_W+1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         wnew = wdiff[VAL_W-1:0];
      end
   end

   // Store write selection.
   always_comb begin
      w_we    = 1'b0;
      g_we    = 1'b0;
      h_we    = 1'b0;
      w_wdata = wnew;
      g_wdata = '0;
      h_wdata = hnew;
      case (state_ff)
         S_EXEC: begin
            case (req_ff.action)
               ACT_LOAD: begin
                  w_we    = 1'b1;
                  g_we    = 1'b1;
                  h_we    = 1'b1;
                  w_wdata = req_ff.value;
                  h_wdata = HIST_ONE;
               end
               ACT_ADD: begin
                  g_we    = 1'b1;
                  g_wdata = gsat;
               end
               ACT_APPLY: begin
                  g_we = skip_hit;
               end
               default: begin
               end
            endcase
         end
         S_HIST: begin
            h_we = 1'b1;
         end
         S_WB: begin
            w_we = 1'b1;
            g_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_payload;
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR: begin
               addr_ff <= ADDR_W'(int'(req_ff.word) * DIM + int'(req_ff.element));
               if (in_range && (req_ff.action == ACT_LOAD || req_ff.action == ACT_ADD ||
                                req_ff.action == ACT_APPLY)) begin
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_WAIT: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               neg_ff   <= g_rd[VAL_W-1];
               gmag_ff  <= g_rd[VAL_W-1] ? VAL_W'(-g_rd) : g_rd;
               w_ff     <= w_rd;
               hist_ff  <= h_rd;
               if (req_ff.action == ACT_APPLY && !skip_hit) begin
                  state_ff <= S_SQ;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_SQ: begin
               sq_ff    <= 64'(gmag_ff) * 64'(gmag_ff);
               state_ff <= S_HIST;
            end
            S_HIST: begin
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (root_done) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  qmag_ff  <= qclamp;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               step_ff  <= (VAL_W+LR_W)'(qmag_ff) * (VAL_W+LR_W)'(lr_ff);
               state_ff <= S_WB;
            end
            S_WB: begin
               rsp_ff.out_word    <= req_ff.word;
               rsp_ff.out_element <= req_ff.element;
               rsp_ff.new_weight  <= wnew;
               rsp_valid_ff       <= 1'b1;
               state_ff           <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= LR_RESET;
         skip_ff <= SKIP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEARNING_RATE: lr_ff   <= csr_data[LR_W-1:0];
            CSR_SKIP_WORD:     skip_ff <= csr_data[SKIP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   apu_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_weight_ram (
      .clock (clock), .we (w_we), .waddr (addr_ff), .wdata (w_wdata),
      .raddr (addr_ff), .rdata (w_rd)
   );

   apu_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grad_ram (
      .clock (clock), .we (g_we), .waddr (addr_ff), .wdata (g_wdata),
      .raddr (addr_ff), .rdata (g_rd)
   );

   apu_ram #(.WIDTH(HIST_W), .DEPTH(DEPTH)) u_hist_ram (
      .clock (clock), .we (h_we), .waddr (addr_ff), .wdata (h_wdata),
      .raddr (addr_ff), .rdata (h_rd)
   );

   apu_root #(.RAD_W(RAD_W)) u_root (
      .clock    (clock),
      .reset    (reset),
      .go       (root_go),
      .radicand (radicand),
      .done     (root_done),
      .root     (root_val)
   );

   apu_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W), .Q_W(VAL_W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (root_val),
      .done  (div_done),
      .quot  (quot)
   );

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/apu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AdaGrad update port checker
// Watches the top level's ports for the sequencing of items and results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   // A taken item makes the engine busy once the start is registered.
   `APU_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   // A result comes as the engine goes idle, after working on an item.
   `APU_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy && $past(busy))
   // At most one result per item, so strobes never sit back to back.
   `APU_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // Reset leaves the engine idle with no result pending.
   `APU_ASSERT_ALWAYS(a_reset_idle, $past(reset), !busy && !rsp_valid && csr_ready)

endmodule

bind adagrad_parameter_update_top apu_checker u_apu_checker (.*);
